[src/lhc_pkg.sv]
// Shared constants and types for the handle cache.
`default_nettype none

package lhc_pkg;

    localparam int ENTRIES  = 4;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KEY_W    = 8;
    localparam int HANDLE_W = 32;
    localparam int AGE_W    = 32;
    localparam int DIM_W    = 16;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [AGE_W-1:0]    age;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } slot_t;

    typedef struct packed {
        logic             en_age;
        logic             en_fill;
        logic             en_clear;
        logic [IDX_W-1:0] idx;
        slot_t            data;
    } slot_wr_t;

endpackage

`default_nettype wire

[src/lhc_slots.sv]
// Slot storage: key, handle, age and picture size per entry.
`default_nettype none

module lhc_slots
    import lhc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [IDX_W-1:0]   rd_idx,
    output slot_t                   rd,
    output logic [ENTRIES-1:0]      occupied,
    input  wire slot_wr_t           wr
);

    logic [KEY_W-1:0]    key_reg    [ENTRIES];
    logic [HANDLE_W-1:0] handle_reg [ENTRIES];
    logic [AGE_W-1:0]    age_reg    [ENTRIES];
    logic [DIM_W-1:0]    width_reg  [ENTRIES];
    logic [DIM_W-1:0]    height_reg [ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                key_reg[i]    <= '0;
                handle_reg[i] <= '0;
                age_reg[i]    <= '0;
            end
        end
        else if (wr.en_clear)
        begin
            key_reg[wr.idx]    <= '0;
            handle_reg[wr.idx] <= '0;
            age_reg[wr.idx]    <= '0;
        end
        else if (wr.en_fill)
        begin
            key_reg[wr.idx]    <= wr.data.key;
            handle_reg[wr.idx] <= wr.data.handle;
            age_reg[wr.idx]    <= wr.data.age;
        end
        else if (wr.en_age)
        begin
            age_reg[wr.idx] <= wr.data.age;
        end
    end

    // size is only read after a fill, no reset
    always_ff @(posedge clk)
    begin
        if (wr.en_fill)
        begin
            width_reg[wr.idx]  <= wr.data.width;
            height_reg[wr.idx] <= wr.data.height;
        end
    end

    always_comb
    begin
        rd.key    = key_reg[rd_idx];
        rd.handle = handle_reg[rd_idx];
        rd.age    = age_reg[rd_idx];
        rd.width  = width_reg[rd_idx];
        rd.height = height_reg[rd_idx];
        for (int i = 0; i < ENTRIES; i++)
        begin
            occupied[i] = (handle_reg[i] != '0);
        end
    end

endmodule

`default_nettype wire

[src/lru_handle_cache.sv]
// Handle cache top level: LRU lookup, fill and clear sequencer.
// Lookup: an accept state, a scan of the slots (one slot per cycle unless an output stall
//   holds a hit), then a fill state on a miss; a hit registers its result word from the scan
//   state and skips the fill, a miss registers it in S_FILL, which an output stall also holds.
// Clear: an accept state, then a sweep over every slot; one word per occupied slot, or one word if none is.
// Reset clears the key, handle and age of every slot, the tick counter and the output valid.
`default_nettype none

module lru_handle_cache
    import lhc_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                command,
    input  wire logic [KEY_W-1:0]    face,
    input  wire logic [HANDLE_W-1:0] load_handle,
    input  wire logic [DIM_W-1:0]    load_width,
    input  wire logic [DIM_W-1:0]    load_height,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [HANDLE_W-1:0]      handle,
    output logic [DIM_W-1:0]         width,
    output logic [DIM_W-1:0]         height,
    output logic                     hit,
    output logic [HANDLE_W-1:0]      released_handle,
    output logic                     last
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FILL, S_CLEAR} state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    victim_reg, victim_next;
    logic [AGE_W-1:0]    vage_reg, vage_next;
    logic [HANDLE_W-1:0] vhandle_reg, vhandle_next;
    logic [AGE_W-1:0]    tick_reg, tick_next;
    logic [KEY_W-1:0]    face_reg, face_next;
    logic [HANDLE_W-1:0] lh_reg, lh_next;
    logic [DIM_W-1:0]    lw_reg, lw_next;
    logic [DIM_W-1:0]    lht_reg, lht_next;
    logic                any_reg, any_next;

    logic                out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic                hit_reg, hit_next;
    logic [HANDLE_W-1:0] rel_reg, rel_next;
    logic                last_reg, last_next;

    slot_t               rd;
    logic [ENTRIES-1:0]  occupied;
    slot_wr_t            wr;

    logic                can_emit;
    logic                last_idx;
    logic                later_occ;
    logic                match;

    lhc_slots u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd       (rd),
        .occupied (occupied),
        .wr       (wr)
    );

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign handle          = handle_reg;
    assign width           = width_reg;
    assign height          = height_reg;
    assign hit             = hit_reg;
    assign released_handle = rel_reg;
    assign last            = last_reg;

    assign can_emit = !out_valid_reg || !out_stall;
    assign last_idx = (idx_reg == IDX_W'(ENTRIES - 1));
    assign match    = occupied[idx_reg] && (rd.key == face_reg);

    always_comb
    begin
        later_occ = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if ((IDX_W'(i) > idx_reg) && occupied[i])
            begin
                later_occ = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        victim_next  = victim_reg;
        vage_next    = vage_reg;
        vhandle_next = vhandle_reg;
        tick_next    = tick_reg;
        face_next    = face_reg;
        lh_next      = lh_reg;
        lw_next      = lw_reg;
        lht_next     = lht_reg;
        any_next     = any_reg;

        out_valid_next = out_valid_reg && out_stall;
        handle_next    = handle_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        hit_next       = hit_reg;
        rel_next       = rel_reg;
        last_next      = last_reg;

        wr.en_age      = 1'b0;
        wr.en_fill     = 1'b0;
        wr.en_clear    = 1'b0;
        wr.idx         = idx_reg;
        wr.data.key    = face_reg;
        wr.data.handle = lh_reg;
        wr.data.age    = tick_reg;
        wr.data.width  = lw_reg;
        wr.data.height = lht_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next  = '0;
                    any_next  = 1'b0;
                    face_next = face;
                    lh_next   = load_handle;
                    lw_next   = load_width;
                    lht_next  = load_height;
                    if (command == CMD_CLEAR)
                    begin
                        tick_next  = '0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        tick_next  = tick_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    if (can_emit)
                    begin
                        wr.en_age      = 1'b1;
                        out_valid_next = 1'b1;
                        handle_next    = rd.handle;
                        width_next     = rd.width;
                        height_next    = rd.height;
                        hit_next       = 1'b1;
                        rel_next       = '0;
                        last_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    if ((idx_reg == '0) || !occupied[idx_reg] || (rd.age < vage_reg))
                    begin
                        victim_next  = idx_reg;
                        vage_next    = rd.age;
                        vhandle_next = rd.handle;
                    end
                    if (last_idx)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_FILL:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    last_next      = 1'b1;
                    if (lh_reg == '0)
                    begin
                        handle_next = '0;
                        width_next  = '0;
                        height_next = '0;
                        rel_next    = '0;
                    end
                    else
                    begin
                        wr.en_fill  = 1'b1;
                        wr.idx      = victim_reg;
                        handle_next = lh_reg;
                        width_next  = lw_reg;
                        height_next = lht_reg;
                        rel_next    = vhandle_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                if (occupied[idx_reg] || (last_idx && !any_reg))
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        handle_next    = '0;
                        width_next     = '0;
                        height_next    = '0;
                        hit_next       = 1'b0;
                        rel_next       = rd.handle;
                        last_next      = !later_occ;
                        any_next       = 1'b1;
                        wr.en_clear    = 1'b1;
                        if (last_idx)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    wr.en_clear = 1'b1;
                    if (last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            tick_reg      <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            victim_reg    <= '0;
            vage_reg      <= '0;
            vhandle_reg   <= '0;
            face_reg      <= '0;
            lh_reg        <= '0;
            lw_reg        <= '0;
            lht_reg       <= '0;
            handle_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            hit_reg       <= 1'b0;
            rel_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            tick_reg      <= tick_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
            victim_reg    <= victim_next;
            vage_reg      <= vage_next;
            vhandle_reg   <= vhandle_next;
            face_reg      <= face_next;
            lh_reg        <= lh_next;
            lw_reg        <= lw_next;
            lht_reg       <= lht_next;
            handle_reg    <= handle_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            hit_reg       <= hit_next;
            rel_reg       <= rel_next;
            last_reg      <= last_next;
        end
    end

endmodule

`default_nettype wire
